/* hdl/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, held off while reset is low.
`define GBS_ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen at a clock edge.
`define GBS_ASSERT_NEVER(lbl, cond, msg) \
  `GBS_ASSERT_CLK(lbl, !(cond), msg)

`endif

/* hdl/gbs_pkg.sv */
`default_nettype none

package gbs_pkg;

  localparam int MAX_KEPT    = 64;
  localparam int COORD_BITS  = 12;
  localparam int THR_W       = 16;
  localparam int SLOT_W      = 6;
  localparam int CNT_W       = $clog2(MAX_KEPT + 1);
  localparam int IDX_W       = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
  localparam int AREA_W      = 2 * COORD_BITS;
  localparam int UNI_W       = AREA_W + 1;
  localparam int PROD_W      = THR_W + UNI_W;

  localparam logic [THR_W-1:0] THR_RESET = 16'd29491;

  typedef struct packed {
    logic                  first_box;
    logic [COORD_BITS-1:0] box_left;
    logic [COORD_BITS-1:0] box_top;
    logic [COORD_BITS-1:0] box_width;
    logic [COORD_BITS-1:0] box_height;
  } in_t;

  typedef struct packed {
    logic              keep_box;
    logic [SLOT_W-1:0] kept_slot;
    logic              store_overflow;
  } out_t;

endpackage

`default_nettype wire

/* hdl/greedy_box_suppression.sv */
`default_nettype none

// Greedy IoU box suppression. Send boxes in descending score order, one word
// per box; set first_box on the first box of a frame to empty the kept list.
// Each box is checked against every kept box of the frame by one shared
// comparison pipeline that reads the kept-box memory one entry per cycle; the
// kept list holds at most MAX_KEPT boxes per frame. A finished box's result
// word waits while the previous result word is still held by out_ready low.
// The input is not ready while a box is in work and becomes ready again in
// the cycle its result word appears. A box is suppressed when its
// intersection with a kept box, times 65536, exceeds overlap_threshold times
// their union; a zero union never suppresses. A surviving box is stored and
// reports its slot, or reports store_overflow when the list is full. Write
// overlap_threshold (Q0.16, reset 29491) through cfg_we/cfg_wdata only while
// the block is idle.
module greedy_box_suppression (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                in_valid,
  output logic                               in_ready,
  input  wire  gbs_pkg::in_t                 in_data,
  output logic                               out_valid,
  input  wire                                out_ready,
  output gbs_pkg::out_t                      out_word,
  input  wire                                cfg_we,
  input  wire  [gbs_pkg::THR_W-1:0]          cfg_wdata
);

  localparam int CB = gbs_pkg::COORD_BITS;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DONE} state_t;

  typedef struct packed {
    logic [CB-1:0]              left;
    logic [CB-1:0]              top;
    logic [CB-1:0]              width;
    logic [CB-1:0]              height;
    logic [gbs_pkg::AREA_W-1:0] area;
  } kept_t;

  // Kept-box memory: one write port (store), one registered read port (scan).
  kept_t mem [gbs_pkg::MAX_KEPT];

  state_t                       state_r, state_nxt;
  logic [gbs_pkg::CNT_W-1:0]    cnt_r;       // boxes kept in this frame
  logic [gbs_pkg::CNT_W-1:0]    idx_r;       // next kept entry to read
  logic                         keep_r;      // no kept box has suppressed us yet
  logic [gbs_pkg::THR_W-1:0]    thr_r;
  logic                         out_valid_r;
  gbs_pkg::out_t                out_word_r;
  logic                         v1_r, v2_r, v3_r, v4_r, v5_r;

  gbs_pkg::in_t                 box_r;
  logic [gbs_pkg::AREA_W-1:0]   area_r;

  // Comparison pipeline datapath.
  kept_t                        mem_q_r;
  logic [CB-1:0]                ovx_r, ovy_r;
  logic [gbs_pkg::AREA_W-1:0]   karea2_r, karea3_r;
  logic [gbs_pkg::AREA_W-1:0]   inter3_r, inter4_r, inter5_r;
  logic [gbs_pkg::UNI_W-1:0]    uni4_r;
  logic [gbs_pkg::PROD_W-1:0]   prod5_r;
  logic                         unz5_r;

  logic                         in_fire, issue, pipe_busy, done_fire, store, hit;
  logic [CB-1:0]                ovx, ovy;
  logic [gbs_pkg::PROD_W-1:0]   inter_sh;

  // One-dimensional overlap of [a0, a0 + al) and [b0, b0 + bl).
  function automatic logic [CB-1:0] overlap_1d(
    input logic [CB-1:0] a0, input logic [CB-1:0] al,
    input logic [CB-1:0] b0, input logic [CB-1:0] bl
  );
    logic [CB:0] lo, ae, be, hi, diff;
    lo = (a0 > b0) ? {1'b0, a0} : {1'b0, b0};
    ae = {1'b0, a0} + {1'b0, al};
    be = {1'b0, b0} + {1'b0, bl};
    hi = (ae < be) ? ae : be;
    diff = hi - lo;
    // The overlap never exceeds either length, so it fits in CB bits.
    return (hi > lo) ? diff[CB-1:0] : '0;
  endfunction

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign issue     = (state_r == S_SCAN) && (idx_r < cnt_r);
  assign pipe_busy = v1_r || v2_r || v3_r || v4_r || v5_r;
  assign done_fire = (state_r == S_DONE) && (!out_valid_r || out_ready);
  assign store     = keep_r && (cnt_r < gbs_pkg::CNT_W'(gbs_pkg::MAX_KEPT));

  assign ovx = overlap_1d(box_r.box_left, box_r.box_width, mem_q_r.left, mem_q_r.width);
  assign ovy = overlap_1d(box_r.box_top, box_r.box_height, mem_q_r.top, mem_q_r.height);

  // Suppress when inter * 2^16 > threshold * union, union nonzero.
  assign inter_sh = {{(gbs_pkg::PROD_W - gbs_pkg::AREA_W - 16){1'b0}}, inter5_r, 16'h0000};
  assign hit      = v5_r && unz5_r && (inter_sh > prod5_r);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_fire) state_nxt = S_SCAN;
      S_SCAN: if (!issue && !pipe_busy) state_nxt = S_DONE;
      S_DONE: if (done_fire) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state and the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      idx_r       <= '0;
      keep_r      <= 1'b0;
      thr_r       <= gbs_pkg::THR_RESET;
      out_valid_r <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) thr_r <= cfg_wdata;

      // Advance the comparison pipeline valids.
      v1_r <= issue;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;

      if (in_fire) begin
        idx_r  <= '0;
        keep_r <= 1'b1;
        // A new frame drops every kept box.
        if (in_data.first_box) cnt_r <= '0;
      end
      if (issue) idx_r <= idx_r + 1'b1;
      if (hit) keep_r <= 1'b0;

      if (done_fire) begin
        out_valid_r                <= 1'b1;
        out_word_r.keep_box        <= keep_r;
        out_word_r.kept_slot       <= store ? gbs_pkg::SLOT_W'(cnt_r) : '0;
        out_word_r.store_overflow  <= keep_r && !store;
        if (store) cnt_r <= cnt_r + 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Hold the box and its area for the whole scan.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      box_r  <= in_data;
      area_r <= gbs_pkg::AREA_W'(in_data.box_width) * gbs_pkg::AREA_W'(in_data.box_height);
    end
  end

  // Kept-box memory.
  always_ff @(posedge clk) begin
    if (done_fire && store) begin
      mem[cnt_r[gbs_pkg::IDX_W-1:0]] <= '{left:   box_r.box_left,
                                          top:    box_r.box_top,
                                          width:  box_r.box_width,
                                          height: box_r.box_height,
                                          area:   area_r};
    end
    if (issue) mem_q_r <= mem[idx_r[gbs_pkg::IDX_W-1:0]];
  end

  // Overlap, intersection, union, threshold product: one stage each.
  always_ff @(posedge clk) begin
    ovx_r    <= ovx;
    ovy_r    <= ovy;
    karea2_r <= mem_q_r.area;

    inter3_r <= gbs_pkg::AREA_W'(ovx_r) * gbs_pkg::AREA_W'(ovy_r);
    karea3_r <= karea2_r;

    uni4_r   <= gbs_pkg::UNI_W'(area_r) + gbs_pkg::UNI_W'(karea3_r)
                - gbs_pkg::UNI_W'(inter3_r);
    inter4_r <= inter3_r;

    prod5_r  <= gbs_pkg::PROD_W'(thr_r) * gbs_pkg::PROD_W'(uni4_r);
    inter5_r <= inter4_r;
    unz5_r   <= (uni4_r != '0);
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

`default_nettype wire

/* hdl/gbs_checker.sv */
`default_nettype none
`include "assert_macros.svh"

module gbs_checker (
  input wire                       clk,
  input wire                       rst_n,
  input wire                       in_valid,
  input wire                       in_ready,
  input wire                       out_valid,
  input wire                       out_ready,
  input wire gbs_pkg::out_t        out_word
);

  // A stalled result word holds.
  `GBS_ASSERT_CLK(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_word), "result word changed while stalled")

  // One box at a time: busy right after an accept.
  `GBS_ASSERT_CLK(a_busy_after_accept, in_valid && in_ready |=> !in_ready, "input ready right after accept")

  // Overflow only on a surviving box.
  `GBS_ASSERT_NEVER(a_ovf_keep, out_valid && out_word.store_overflow && !out_word.keep_box, "overflow on suppressed box")

  // Suppressed or overflowed boxes report slot zero.
  `GBS_ASSERT_NEVER(a_slot_zero, out_valid && (!out_word.keep_box || out_word.store_overflow) && (out_word.kept_slot != '0), "nonzero slot for unstored box")

endmodule

bind greedy_box_suppression gbs_checker u_gbs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_word  (out_word)
);

`default_nettype wire

/* test/tb_greedy_box_suppression.sv */
`timescale 1ns / 100ps

module tb_greedy_box_suppression;

  // Shapes of random boxes: near the frame's cluster, anywhere, or tiny.
  typedef enum int {SHAPE_NEAR, SHAPE_ANY, SHAPE_TINY} shape_t;

  localparam int GAP_MAX     = 18;
  localparam int PHASE_ITEMS = 86;
  localparam int DRAIN_WAIT  = gbs_pkg::MAX_KEPT + 32;

  // Track the kept list of the current frame, predict a verdict per box and
  // hold those verdicts until the block reports them.
  class box_scoreboard;
    logic [gbs_pkg::THR_W-1:0]  overlap_threshold;
    gbs_pkg::in_t               kept_box[gbs_pkg::MAX_KEPT];
    logic [gbs_pkg::AREA_W-1:0] kept_area[gbs_pkg::MAX_KEPT];
    int unsigned                kept_count;
    gbs_pkg::out_t              pending_verdicts[$];
    int unsigned                mismatches;
    int unsigned                checked;
    int unsigned                n_kept;
    int unsigned                n_suppressed;
    int unsigned                n_overflow;

    function new();
      overlap_threshold = gbs_pkg::THR_RESET;
      kept_count        = 0;
      mismatches        = 0;
      checked           = 0;
      n_kept            = 0;
      n_suppressed      = 0;
      n_overflow        = 0;
    endfunction

    // Overlap of [a0, a0 + al) and [b0, b0 + bl); ends need one extra bit.
    function logic [gbs_pkg::COORD_BITS:0] span_overlap(
      logic [gbs_pkg::COORD_BITS-1:0] a0,
      logic [gbs_pkg::COORD_BITS-1:0] al,
      logic [gbs_pkg::COORD_BITS-1:0] b0,
      logic [gbs_pkg::COORD_BITS-1:0] bl);
      logic [gbs_pkg::COORD_BITS:0] lo;
      logic [gbs_pkg::COORD_BITS:0] hi;
      logic [gbs_pkg::COORD_BITS:0] a_end;
      logic [gbs_pkg::COORD_BITS:0] b_end;
      lo    = (a0 > b0) ? {1'b0, a0} : {1'b0, b0};
      a_end = {1'b0, a0} + {1'b0, al};
      b_end = {1'b0, b0} + {1'b0, bl};
      hi    = (a_end < b_end) ? a_end : b_end;
      return (hi > lo) ? hi - lo : '0;
    endfunction

    function void note_box(gbs_pkg::in_t box);
      gbs_pkg::out_t              verdict;
      logic [gbs_pkg::AREA_W-1:0] area;
      logic [gbs_pkg::AREA_W-1:0] inter;
      logic [gbs_pkg::UNI_W-1:0]  uni;
      logic [gbs_pkg::PROD_W-1:0] scaled_inter;
      logic [gbs_pkg::PROD_W-1:0] scaled_union;
      if (box.first_box) begin
        kept_count = 0;
      end
      area = gbs_pkg::AREA_W'(box.box_width) * gbs_pkg::AREA_W'(box.box_height);
      verdict = '0;
      verdict.keep_box = 1'b1;
      for (int j = 0; j < kept_count; j++) begin
        inter = gbs_pkg::AREA_W'(span_overlap(box.box_left, box.box_width,
                                              kept_box[j].box_left,
                                              kept_box[j].box_width)) *
                gbs_pkg::AREA_W'(span_overlap(box.box_top, box.box_height,
                                              kept_box[j].box_top,
                                              kept_box[j].box_height));
        uni = gbs_pkg::UNI_W'(area) + gbs_pkg::UNI_W'(kept_area[j])
              - gbs_pkg::UNI_W'(inter);
        scaled_inter = gbs_pkg::PROD_W'(inter) << gbs_pkg::THR_W;
        scaled_union = gbs_pkg::PROD_W'(overlap_threshold) * gbs_pkg::PROD_W'(uni);
        if (uni != '0 && scaled_inter > scaled_union) begin
          verdict.keep_box = 1'b0;
        end
      end
      if (verdict.keep_box) begin
        if (kept_count < gbs_pkg::MAX_KEPT) begin
          kept_box[kept_count]  = box;
          kept_area[kept_count] = area;
          verdict.kept_slot     = gbs_pkg::SLOT_W'(kept_count);
          kept_count++;
        end else begin
          verdict.store_overflow = 1'b1;
        end
      end
      pending_verdicts = {pending_verdicts, verdict};
    endfunction

    function void check_verdict(gbs_pkg::out_t got);
      gbs_pkg::out_t want;
      if (pending_verdicts.size() == 0) begin
        $error("result word with no box pending: keep_box=%0d kept_slot=%0d overflow=%0d",
               got.keep_box, got.kept_slot, got.store_overflow);
        mismatches++;
        return;
      end
      want = pending_verdicts.pop_front();
      checked++;
      if (want.store_overflow) begin
        n_overflow++;
      end else if (want.keep_box) begin
        n_kept++;
      end else begin
        n_suppressed++;
      end
      if (got.keep_box !== want.keep_box) begin
        $error("keep_box: expected %0d, got %0d", want.keep_box, got.keep_box);
        mismatches++;
      end
      if (got.kept_slot !== want.kept_slot) begin
        $error("kept_slot: expected %0d, got %0d", want.kept_slot, got.kept_slot);
        mismatches++;
      end
      if (got.store_overflow !== want.store_overflow) begin
        $error("store_overflow: expected %0d, got %0d",
               want.store_overflow, got.store_overflow);
        mismatches++;
      end
    endfunction
  endclass

  logic                      clk       = 1'b0;
  logic                      rst_n     = 1'b0;
  logic                      in_valid  = 1'b0;
  logic                      in_ready;
  gbs_pkg::in_t              in_data   = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  gbs_pkg::out_t             out_word;
  logic                      cfg_we    = 1'b0;
  logic [gbs_pkg::THR_W-1:0] cfg_wdata = '0;

  box_scoreboard sb = new();
  int unsigned   n_settings = 1;

  always #5 clk = ~clk;

  greedy_box_suppression i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  function automatic gbs_pkg::in_t mk_box(bit first, int left, int top, int width,
                                          int height);
    gbs_pkg::in_t box;
    box.first_box  = first;
    box.box_left   = gbs_pkg::COORD_BITS'(left);
    box.box_top    = gbs_pkg::COORD_BITS'(top);
    box.box_width  = gbs_pkg::COORD_BITS'(width);
    box.box_height = gbs_pkg::COORD_BITS'(height);
    return box;
  endfunction

  // Offer one box word after an idle gap of the given length and hold it until accepted.
  // Valid is lowered only when a gap follows, so back-to-back words keep it
  // high without a second assignment in the same step.
  task automatic send_box(gbs_pkg::in_t box, int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= box;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_box(box);
  endtask

  // Drop valid and wait until every predicted verdict has come back.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending_verdicts.size() != 0) @(posedge clk);
  endtask

  // Write the threshold while the block is idle; the model follows at once.
  task automatic write_threshold(logic [gbs_pkg::THR_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.overlap_threshold = value;
    n_settings++;
  endtask

  // Random frames. Most frames are short, start with first_box and cluster
  // their boxes around one spot so that overlaps land near the threshold.
  // Some frames are long runs of tiny boxes that fill the kept list and go
  // on into overflow. A few frames omit first_box and extend the previous
  // list, and a rare stray first_box cuts a frame short.
  task automatic run_phase(int n_items);
    int                             sent;
    int                             frame_len;
    int                             jit;
    int                             k;
    int                             roll;
    bit                             long_frame;
    bit                             burst;
    logic [gbs_pkg::COORD_BITS-1:0] cx;
    logic [gbs_pkg::COORD_BITS-1:0] cy;
    logic [gbs_pkg::COORD_BITS-1:0] w0;
    logic [gbs_pkg::COORD_BITS-1:0] h0;
    shape_t                         shape;
    gbs_pkg::in_t                   box;
    sent = 0;
    while (sent < n_items) begin
      long_frame = ($urandom_range(0, 5) == 0);
      frame_len  = long_frame ? $urandom_range(70, 80) : $urandom_range(1, 14);
      burst      = ($urandom_range(0, 3) == 0);
      cx  = gbs_pkg::COORD_BITS'($urandom);
      cy  = gbs_pkg::COORD_BITS'($urandom);
      w0  = ($urandom_range(0, 7) == 0) ? gbs_pkg::COORD_BITS'($urandom)
                                        : gbs_pkg::COORD_BITS'($urandom_range(1, 300));
      h0  = ($urandom_range(0, 7) == 0) ? gbs_pkg::COORD_BITS'($urandom)
                                        : gbs_pkg::COORD_BITS'($urandom_range(1, 300));
      jit = $urandom_range(0, 40);
      k   = 0;
      while (k < frame_len && sent < n_items) begin
        roll = $urandom_range(0, 19);
        if (long_frame) begin
          shape = (roll != 0) ? SHAPE_TINY : SHAPE_NEAR;
        end else begin
          shape = (roll < 10) ? SHAPE_NEAR : (roll < 14) ? SHAPE_ANY : SHAPE_TINY;
        end
        case (shape)
          SHAPE_NEAR: begin
            box.box_left   = gbs_pkg::COORD_BITS'(cx + $urandom_range(0, 2 * jit) - jit);
            box.box_top    = gbs_pkg::COORD_BITS'(cy + $urandom_range(0, 2 * jit) - jit);
            box.box_width  = gbs_pkg::COORD_BITS'(w0 + $urandom_range(0, 2 * jit) - jit);
            box.box_height = gbs_pkg::COORD_BITS'(h0 + $urandom_range(0, 2 * jit) - jit);
          end
          SHAPE_ANY: begin
            box.box_left   = gbs_pkg::COORD_BITS'($urandom);
            box.box_top    = gbs_pkg::COORD_BITS'($urandom);
            box.box_width  = gbs_pkg::COORD_BITS'($urandom);
            box.box_height = gbs_pkg::COORD_BITS'($urandom);
          end
          default: begin
            box.box_left   = gbs_pkg::COORD_BITS'($urandom);
            box.box_top    = gbs_pkg::COORD_BITS'($urandom);
            box.box_width  = gbs_pkg::COORD_BITS'($urandom_range(0, 2));
            box.box_height = gbs_pkg::COORD_BITS'($urandom_range(0, 2));
          end
        endcase
        if (k == 0) begin
          box.first_box = ($urandom_range(0, 9) != 0);
        end else begin
          box.first_box = ($urandom_range(0, 39) == 0);
        end
        send_box(box, burst ? 0 : $urandom_range(0, GAP_MAX));
        k++;
        sent++;
      end
    end
  endtask

  // Result side: a random stall, possibly none, before each word, with stretches of full rate.
  initial begin : result_sink
    int gap;
    int stretch;
    bit burst;
    stretch = 0;
    burst   = 1'b0;
    @(posedge rst_n);
    forever begin
      if (stretch == 0) begin
        burst   = ($urandom_range(0, 3) == 0);
        stretch = $urandom_range(8, 40);
      end
      stretch--;
      gap = burst ? 0 : $urandom_range(0, GAP_MAX);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      sb.check_verdict(out_word);
    end
  end

  initial begin : stimulus
    logic [gbs_pkg::THR_W-1:0] thr_plan[8];
    thr_plan = '{16'd0, 16'hFFFF, 16'd1, 16'hFFFE, 16'h8000, 16'h0000, 16'h0000,
                 gbs_pkg::THR_RESET};
    thr_plan[5] = gbs_pkg::THR_W'($urandom);
    thr_plan[6] = gbs_pkg::THR_W'($urandom);

    // Hold reset from time zero, then release it once.
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed boxes under the reset threshold. The first box carries no
    // first_box flag, so it relies on the list being empty after reset.
    send_box(mk_box(0, 10, 10, 20, 20), $urandom_range(0, GAP_MAX));
    // Identical box: full overlap, suppressed.
    send_box(mk_box(0, 10, 10, 20, 20), 0);
    // Half-shifted box: IoU of one third stays below the threshold.
    send_box(mk_box(0, 20, 10, 20, 20), $urandom_range(0, GAP_MAX));
    // Zero-size box, then a second on the same spot: both kept, the pair with a zero union.
    send_box(mk_box(0, 15, 15, 0, 0), 0);
    send_box(mk_box(0, 15, 15, 0, 0), $urandom_range(0, GAP_MAX));
    // New frame with the largest box the fields allow.
    send_box(mk_box(1, 0, 0, 4095, 4095), 0);
    // Corner-to-corner at the far edge: touching, no overlap.
    send_box(mk_box(0, 4095, 4095, 4095, 4095), $urandom_range(0, GAP_MAX));
    send_box(mk_box(0, 4095, 4095, 4095, 4095), 0);
    send_box(mk_box(0, 0, 0, 4095, 4095), 0);
    // Right half of the big box: IoU of one half, suppressed.
    send_box(mk_box(0, 2048, 0, 2047, 4095), $urandom_range(0, GAP_MAX));
    // Degenerate boxes with one side zero: never suppressed.
    send_box(mk_box(0, 1, 1, 4094, 0), 0);
    send_box(mk_box(0, 0, 0, 0, 4095), $urandom_range(0, GAP_MAX));
    // Fresh frame with edge-touching neighbors and a single-pixel box.
    send_box(mk_box(1, 100, 100, 10, 10), 0);
    send_box(mk_box(0, 110, 100, 10, 10), 0);
    send_box(mk_box(0, 100, 110, 10, 10), $urandom_range(0, GAP_MAX));
    send_box(mk_box(0, 105, 105, 10, 10), 0);
    send_box(mk_box(0, 4095, 0, 1, 1), $urandom_range(0, GAP_MAX));
    send_box(mk_box(1, 2730, 1365, 1365, 2730), 0);
    drain();

    // Random phases, one threshold each, extremes first.
    for (int p = 0; p < 8; p++) begin
      write_threshold(thr_plan[p]);
      run_phase(PHASE_ITEMS);
      drain();
    end

    // Give any stray word time to show up before the verdict.
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Checked %0d box verdicts over %0d threshold settings.",
             sb.checked, n_settings);
    $display("Verdicts: %0d kept, %0d suppressed, %0d kept-list overflows.",
             sb.n_kept, sb.n_suppressed, sb.n_overflow);
    if (sb.mismatches == 0 && sb.pending_verdicts.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Stop a hung run well past the slowest legal one.
  initial begin : watchdog
    #4_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
